[hdl/hbw_pkg.sv]
// ----------------------------------------------------------------------------
// hbw_pkg
// Shared types, codes and widths of the heartbeat watchdog.
// ----------------------------------------------------------------------------
package hbw_pkg;

    localparam int CHANNELS_DEF  = 16;
    localparam int TIME_BITS_DEF = 32;
    localparam int MAX_RESULTS   = 16;

    localparam int CMD_W    = 3;
    localparam int TID_W    = 4;
    localparam int TMO_W    = 24;
    localparam int STATUS_W = 3;
    localparam int ID_W     = 4;
    localparam int FOUND_W  = $clog2(MAX_RESULTS + 1);

    localparam logic [CMD_W-1:0] CMD_REGISTER  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_HEARTBEAT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SET_PAUSE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TICK      = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SCAN      = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_UNKNOWN = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_EXPIRED = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_NONE    = 3'd4;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     channel_id;
        logic                last;
    } out_beat_t;

endpackage

[hdl/hbw_in_if.sv]
// ----------------------------------------------------------------------------
// hbw_in_if
// Command channel of the heartbeat watchdog: valid, ready and one command.
// ----------------------------------------------------------------------------
interface hbw_in_if
    import hbw_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    logic [TID_W-1:0] chan_sel;
    logic [TMO_W-1:0] limit_ms;
    logic             pause_flag;

    modport source (output valid, output cmd, output chan_sel, output limit_ms,
                    output pause_flag, input ready);
    modport sink (input valid, input cmd, input chan_sel, input limit_ms,
                  input pause_flag, output ready);
endinterface

[hdl/hbw_out_if.sv]
// ----------------------------------------------------------------------------
// hbw_out_if
// Result channel of the heartbeat watchdog: valid, ready and one result.
// ----------------------------------------------------------------------------
interface hbw_out_if
    import hbw_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     channel_id;
    logic                last;

    modport source (output valid, output status, output channel_id, output last,
                    input ready);
    modport sink (input valid, input status, input channel_id, input last,
                  output ready);
endinterface

[hdl/hbw_chan_mem.sv]
// ----------------------------------------------------------------------------
// hbw_chan_mem
// Channel table: timeout and last-beat memories, one write and one registered
// read port each.
// ----------------------------------------------------------------------------
module hbw_chan_mem
    import hbw_pkg::*;
#(
    parameter int CHANNELS  = CHANNELS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF,
    parameter int IDX_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
)
(
    input  logic                 clk,
    input  logic                 tmo_we,
    input  logic                 beat_we,
    input  logic [IDX_W-1:0]     wr_addr,
    input  logic [TMO_W-1:0]     wr_tmo,
    input  logic [TIME_BITS-1:0] wr_beat,
    input  logic [IDX_W-1:0]     rd_addr,
    output logic [TMO_W-1:0]     rd_tmo,
    output logic [TIME_BITS-1:0] rd_beat
);

    logic [TMO_W-1:0]     tmo_mem  [CHANNELS];
    logic [TIME_BITS-1:0] beat_mem [CHANNELS];

    always_ff @(posedge clk)
    begin
        if (tmo_we)
        begin
            tmo_mem[wr_addr] <= wr_tmo;
        end
        rd_tmo <= tmo_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (beat_we)
        begin
            beat_mem[wr_addr] <= wr_beat;
        end
        rd_beat <= beat_mem[rd_addr];
    end

endmodule

[hdl/hbw_out_reg.sv]
// ----------------------------------------------------------------------------
// hbw_out_reg
// Output register of the result channel; holds one result until it is taken.
// ----------------------------------------------------------------------------
module hbw_out_reg
    import hbw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  out_beat_t  din,
    output logic       free,
    hbw_out_if.source  rsp
);

    logic      valid_reg;
    logic      valid_next;
    out_beat_t data_reg;

    assign free       = !valid_reg || rsp.ready;
    assign valid_next = load || (valid_reg && !rsp.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= din;
        end
    end

    assign rsp.valid      = valid_reg;
    assign rsp.status     = data_reg.status;
    assign rsp.channel_id = data_reg.channel_id;
    assign rsp.last       = data_reg.last;

endmodule

[hdl/multi_channel_heartbeat_watchdog.sv]
// ----------------------------------------------------------------------------
// multi_channel_heartbeat_watchdog
// Watches up to CHANNELS channels for missing heartbeats and reports expiry.
// ----------------------------------------------------------------------------
// One command is handled at a time. A command is taken in the idle state;
// register, heartbeat, set pause and tick are then carried out in the execute
// state once the result channel is free. A scan walks the registered channels
// in id order through the single read port of the channel table, addressing
// each channel and then comparing it; it stops early after sixteen expired
// channels. Results wait in an output register, and a new command is taken
// while a result still waits. Timeouts and beat times live in memories that
// are written at registration and need no clearing pass after reset.
// ----------------------------------------------------------------------------
module multi_channel_heartbeat_watchdog
    import hbw_pkg::*;
#(
    parameter int CHANNELS  = CHANNELS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    hbw_in_if.sink   req,
    hbw_out_if.source rsp
);

    localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W    = $clog2(CHANNELS + 1);
    localparam int CMP_W    = (CNT_W > TID_W) ? CNT_W : TID_W;
    localparam int ID_EXT_W = (IDX_W > ID_W) ? IDX_W : ID_W;
    localparam int CMPT_W   = (TIME_BITS > TMO_W) ? TIME_BITS : TMO_W;

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_EXEC    = 5'b00010,
        ST_SCAN_RD = 5'b00100,
        ST_SCAN_CK = 5'b01000,
        ST_FINISH  = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [CMD_W-1:0]     cmd_reg;
    logic [TID_W-1:0]     tid_reg;
    logic [TMO_W-1:0]     tmo_reg;
    logic                 pause_reg;
    logic [TIME_BITS-1:0] time_reg, time_next;
    logic [CNT_W-1:0]     nfree_reg, nfree_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [FOUND_W-1:0]   found_reg, found_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]     pend_id_reg, pend_id_next;
    logic [CHANNELS-1:0]  paused_reg, paused_next;
    logic [CHANNELS-1:0]  expired_reg, expired_next;

    logic                 tmo_we, beat_we;
    logic [IDX_W-1:0]     wr_addr, rd_addr;
    logic [TMO_W-1:0]     rd_tmo;
    logic [TIME_BITS-1:0] rd_beat;
    logic [TIME_BITS-1:0] elapsed;
    logic                 expire_hit;
    logic                 out_load, out_free;
    out_beat_t            out_din;

    logic [IDX_W-1:0]     tid_idx, nfree_idx, scan_idx;
    logic [ID_EXT_W-1:0]  nfree_id_ext, scan_id_ext, pend_id_ext;
    logic                 tid_unknown, table_full;

    assign tid_idx     = IDX_W'(tid_reg);
    assign nfree_idx   = nfree_reg[IDX_W-1:0];
    assign scan_idx    = idx_reg[IDX_W-1:0];
    assign nfree_id_ext = ID_EXT_W'(nfree_idx);
    assign scan_id_ext  = ID_EXT_W'(scan_idx);
    assign pend_id_ext  = ID_EXT_W'(pend_id_reg);
    assign tid_unknown = CMP_W'(tid_reg) >= CMP_W'(nfree_reg);
    assign table_full  = nfree_reg == CNT_W'(CHANNELS);
    assign rd_addr     = scan_idx;

    // Elapsed time wraps with the time counter.
    assign elapsed    = time_reg - rd_beat;
    assign expire_hit = CMPT_W'(elapsed) > CMPT_W'(rd_tmo);

    assign req.ready = state_reg == ST_IDLE;

    hbw_chan_mem #(
        .CHANNELS  (CHANNELS),
        .TIME_BITS (TIME_BITS),
        .IDX_W     (IDX_W)
    ) u_mem (
        .clk     (clk),
        .tmo_we  (tmo_we),
        .beat_we (beat_we),
        .wr_addr (wr_addr),
        .wr_tmo  (tmo_reg),
        .wr_beat (time_reg),
        .rd_addr (rd_addr),
        .rd_tmo  (rd_tmo),
        .rd_beat (rd_beat)
    );

    hbw_out_reg u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (out_load),
        .din   (out_din),
        .free  (out_free),
        .rsp   (rsp)
    );

    always_comb
    begin
        state_next      = state_reg;
        time_next       = time_reg;
        nfree_next      = nfree_reg;
        idx_next        = idx_reg;
        found_next      = found_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        paused_next     = paused_reg;
        expired_next    = expired_reg;
        tmo_we          = 1'b0;
        beat_we         = 1'b0;
        wr_addr         = tid_idx;
        out_load        = 1'b0;
        out_din.status     = STAT_OK;
        out_din.channel_id = '0;
        out_din.last       = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                unique case (cmd_reg)
                    CMD_REGISTER:
                    begin
                        if (out_free)
                        begin
                            out_load   = 1'b1;
                            state_next = ST_IDLE;
                            if (table_full)
                            begin
                                out_din.status = STAT_FULL;
                            end
                            else
                            begin
                                wr_addr                 = nfree_idx;
                                tmo_we                  = 1'b1;
                                beat_we                 = 1'b1;
                                paused_next[nfree_idx]  = 1'b0;
                                expired_next[nfree_idx] = 1'b0;
                                nfree_next              = nfree_reg + 1'b1;
                                out_din.channel_id      = nfree_id_ext[ID_W-1:0];
                            end
                        end
                    end
                    CMD_HEARTBEAT, CMD_SET_PAUSE:
                    begin
                        if (out_free)
                        begin
                            out_load           = 1'b1;
                            state_next         = ST_IDLE;
                            out_din.channel_id = tid_reg;
                            if (tid_unknown)
                            begin
                                out_din.status = STAT_UNKNOWN;
                            end
                            else
                            begin
                                if (cmd_reg == CMD_SET_PAUSE)
                                begin
                                    paused_next[tid_idx] = pause_reg;
                                end
                                // A resume restarts the timing just as a heartbeat does.
                                if (cmd_reg == CMD_HEARTBEAT || !pause_reg)
                                begin
                                    beat_we               = 1'b1;
                                    expired_next[tid_idx] = 1'b0;
                                end
                            end
                        end
                    end
                    CMD_TICK:
                    begin
                        if (out_free)
                        begin
                            out_load   = 1'b1;
                            state_next = ST_IDLE;
                            time_next  = time_reg + 1'b1;
                        end
                    end
                    CMD_SCAN:
                    begin
                        idx_next        = '0;
                        found_next      = '0;
                        pend_valid_next = 1'b0;
                        state_next      = ST_SCAN_RD;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_SCAN_RD:
            begin
                if (idx_reg >= nfree_reg || found_reg == FOUND_W'(MAX_RESULTS))
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_SCAN_CK;
                end
            end
            ST_SCAN_CK:
            begin
                if (paused_reg[scan_idx] || expired_reg[scan_idx] || !expire_hit)
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_SCAN_RD;
                end
                else if (!pend_valid_reg || out_free)
                begin
                    // The previous hit is sent only now, once it is known not to be
                    // the final result of the scan.
                    if (pend_valid_reg)
                    begin
                        out_load           = 1'b1;
                        out_din.status     = STAT_EXPIRED;
                        out_din.channel_id = pend_id_ext[ID_W-1:0];
                        out_din.last       = 1'b0;
                    end
                    expired_next[scan_idx] = 1'b1;
                    pend_valid_next        = 1'b1;
                    pend_id_next           = scan_idx;
                    found_next             = found_reg + 1'b1;
                    idx_next               = idx_reg + 1'b1;
                    state_next             = ST_SCAN_RD;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                    if (pend_valid_reg)
                    begin
                        out_din.status     = STAT_EXPIRED;
                        out_din.channel_id = pend_id_ext[ID_W-1:0];
                    end
                    else
                    begin
                        out_din.status = STAT_NONE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            time_reg       <= '0;
            nfree_reg      <= '0;
            idx_reg        <= '0;
            found_reg      <= '0;
            pend_valid_reg <= 1'b0;
            paused_reg     <= '0;
            expired_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            time_reg       <= time_next;
            nfree_reg      <= nfree_next;
            idx_reg        <= idx_next;
            found_reg      <= found_next;
            pend_valid_reg <= pend_valid_next;
            paused_reg     <= paused_next;
            expired_reg    <= expired_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_id_reg <= pend_id_next;
        if (req.valid && req.ready)
        begin
            cmd_reg   <= req.cmd;
            tid_reg   <= req.chan_sel;
            tmo_reg   <= req.limit_ms;
            pause_reg <= req.pause_flag;
        end
    end

`ifndef SYNTH
    a_found_bound: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg <= FOUND_W'(MAX_RESULTS))
        else $error("scan reported more channels than allowed");

    a_nfree_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nfree_reg <= CNT_W'(CHANNELS))
        else $error("registration count beyond table size");

    a_pend_marked: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> expired_reg[pend_id_reg])
        else $error("held expiry result for a channel not marked expired");

    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN_RD || state_reg == ST_SCAN_CK) |-> !(tmo_we || beat_we))
        else $error("channel table written during a scan");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("result loaded over one still waiting");
`endif

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multi-channel heartbeat watchdog. A directed
// opening covers registration, unknown channels, pause and resume, ticks,
// scans with and without expiry and the unused commands. A random phase of
// tick bursts, scans, registrations, beats, pauses and unused commands follows.
// A predictor keeps its own channel table and checks every result beat in order.
// ----------------------------------------------------------------------------
module tb_top;
    import hbw_pkg::*;

    localparam int NCH = CHANNELS_DEF;
    localparam int RANDOM_ITEMS = 200;
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = CMD_SCAN + 3'd1;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = '1;
    localparam logic [TMO_W-1:0] TMO_MAX = '1;

    typedef struct {
        logic [CMD_W-1:0] cmd;
        logic [TID_W-1:0] chan_sel;
        logic [TMO_W-1:0] limit_ms;
        logic             pause_flag;
    } cmd_item_t;

    logic clk = 1'b0;
    logic rst_n;

    hbw_in_if  req_if ();
    hbw_out_if rsp_if ();

    multi_channel_heartbeat_watchdog uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // Stimulus waiting to be driven and results still owed by the block.
    cmd_item_t cmd_queue[$];
    out_beat_t awaited_results[$];

    // Predicted channel table.
    logic [TIME_BITS_DEF-1:0] now_ms = '0;
    int                       reg_count = 0;
    logic [TMO_W-1:0]         chan_limit [NCH] = '{default: '0};
    logic [TIME_BITS_DEF-1:0] chan_beat_at [NCH] = '{default: '0};
    logic                     chan_held [NCH] = '{default: 1'b0};
    logic                     chan_flagged [NCH] = '{default: 1'b0};

    int   mismatches = 0;
    int   items_taken = 0;
    int   results_taken = 0;
    logic cmd_taken;

    always #5 clk = ~clk;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    task automatic push_cmd(input int unsigned c, input int unsigned sel,
                            input int unsigned lim, input int unsigned pf);
        cmd_item_t item;
        item.cmd        = CMD_W'(c);
        item.chan_sel   = TID_W'(sel);
        item.limit_ms   = TMO_W'(lim);
        item.pause_flag = 1'(pf);
        cmd_queue.insert(cmd_queue.size(), item);
    endtask

    // Fields that the command does not use are filled with noise.
    task automatic push_any(input logic [CMD_W-1:0] c);
        push_cmd(c, $urandom_range(0, 15), $urandom(), $urandom_range(0, 1));
    endtask

    function automatic logic [TID_W-1:0] pick_channel(input int known);
        if (known == 0 || $urandom_range(0, 99) < 15)
            return TID_W'($urandom_range(0, 15));
        return TID_W'($urandom_range(0, known - 1));
    endfunction

    task automatic predict_watchdog_results(input cmd_item_t item);
        out_beat_t                r;
        logic [TIME_BITS_DEF-1:0] elapsed;
        int                       found;
        found = 0;
        r.last = 1'b1;
        r.channel_id = '0;
        unique case (item.cmd)
            CMD_REGISTER:
            begin
                if (reg_count >= NCH)
                begin
                    r.status = STAT_FULL;
                end
                else
                begin
                    chan_limit[reg_count]   = item.limit_ms;
                    chan_beat_at[reg_count] = now_ms;
                    chan_held[reg_count]    = 1'b0;
                    chan_flagged[reg_count] = 1'b0;
                    r.status     = STAT_OK;
                    r.channel_id = reg_count[ID_W-1:0];
                    reg_count++;
                end
                awaited_results.insert(awaited_results.size(), r);
            end
            CMD_HEARTBEAT, CMD_SET_PAUSE:
            begin
                r.channel_id = item.chan_sel;
                if (item.chan_sel >= reg_count)
                begin
                    r.status = STAT_UNKNOWN;
                end
                else
                begin
                    if (item.cmd == CMD_SET_PAUSE)
                        chan_held[item.chan_sel] = item.pause_flag;
                    // A resume restarts the timing just as a heartbeat does.
                    if (item.cmd == CMD_HEARTBEAT || !item.pause_flag)
                    begin
                        chan_beat_at[item.chan_sel] = now_ms;
                        chan_flagged[item.chan_sel] = 1'b0;
                    end
                    r.status = STAT_OK;
                end
                awaited_results.insert(awaited_results.size(), r);
            end
            CMD_TICK:
            begin
                now_ms = now_ms + 1'b1;
                r.status = STAT_OK;
                awaited_results.insert(awaited_results.size(), r);
            end
            CMD_SCAN:
            begin
                for (int i = 0; i < NCH; i++)
                begin
                    if (i < reg_count && found < MAX_RESULTS && !chan_held[i]
                        && !chan_flagged[i])
                    begin
                        elapsed = now_ms - chan_beat_at[i];
                        if (elapsed > chan_limit[i])
                        begin
                            chan_flagged[i] = 1'b1;
                            r.status     = STAT_EXPIRED;
                            r.channel_id = i[ID_W-1:0];
                            r.last       = 1'b0;
                            awaited_results.insert(awaited_results.size(), r);
                            found++;
                        end
                    end
                end
                if (found == 0)
                begin
                    r.status     = STAT_NONE;
                    r.channel_id = '0;
                    r.last       = 1'b1;
                    awaited_results.insert(awaited_results.size(), r);
                end
                else
                begin
                    awaited_results[awaited_results.size() - 1].last = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // Command driver: a new beat is offered only once the previous one was taken.
    always @(negedge clk)
    begin : drive_cmd
        cmd_item_t item;
        logic      calm;
        calm = items_taken >= 90 && items_taken < 160;
        if (!rst_n)
        begin
            req_if.valid <= 1'b0;
        end
        else if (!req_if.valid || cmd_taken)
        begin
            if (cmd_queue.size() != 0 && (calm || $urandom_range(0, 99) >= 6))
            begin
                item = cmd_queue.pop_front();
                req_if.valid      <= 1'b1;
                req_if.cmd        <= item.cmd;
                req_if.chan_sel   <= item.chan_sel;
                req_if.limit_ms   <= item.limit_ms;
                req_if.pause_flag <= item.pause_flag;
            end
            else
            begin
                req_if.valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin : drive_ready
        logic calm;
        calm = results_taken >= 90 && results_taken < 160;
        rsp_if.ready <= rst_n && (calm || $urandom_range(0, 99) >= 6);
    end

    always @(posedge clk)
    begin : monitor
        cmd_item_t item;
        out_beat_t want;
        if (!rst_n)
        begin
            cmd_taken <= 1'b0;
        end
        else
        begin
            cmd_taken <= req_if.valid && req_if.ready;
            if (req_if.valid && req_if.ready)
            begin
                item.cmd        = req_if.cmd;
                item.chan_sel   = req_if.chan_sel;
                item.limit_ms   = req_if.limit_ms;
                item.pause_flag = req_if.pause_flag;
                predict_watchdog_results(item);
                items_taken++;
            end
            if (rsp_if.valid && rsp_if.ready)
            begin
                results_taken++;
                if (awaited_results.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result status %0d id %0d",
                                              rsp_if.status, rsp_if.channel_id));
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (rsp_if.status !== want.status)
                        report_mismatch($sformatf("status %0d, wanted %0d",
                                                  rsp_if.status, want.status));
                    if (rsp_if.channel_id !== want.channel_id)
                        report_mismatch($sformatf("channel_id %0d, wanted %0d",
                                                  rsp_if.channel_id, want.channel_id));
                    if (rsp_if.last !== want.last)
                        report_mismatch($sformatf("last %0b, wanted %0b",
                                                  rsp_if.last, want.last));
                end
            end
        end
    end

    initial
    begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : stimulus
        int known;
        int issued;
        int pick;
        int burst;
        rst_n = 1'b0;

        // Empty table, then a few channels with the extreme timeouts.
        push_any(CMD_SCAN);
        push_cmd(CMD_HEARTBEAT, 4'd0, $urandom(), 1'b0);
        push_cmd(CMD_SET_PAUSE, 4'd15, $urandom(), 1'b1);
        push_cmd(CMD_REGISTER, $urandom_range(0, 15), '0, $urandom_range(0, 1));
        push_cmd(CMD_REGISTER, $urandom_range(0, 15), TMO_MAX, $urandom_range(0, 1));
        push_cmd(CMD_REGISTER, $urandom_range(0, 15), 24'd3, $urandom_range(0, 1));
        push_cmd(CMD_HEARTBEAT, 4'd3, $urandom(), 1'b1);
        push_any(CMD_TICK);
        push_any(CMD_SCAN);
        // A channel already reported stays quiet until it is beaten again.
        push_any(CMD_SCAN);
        push_cmd(CMD_HEARTBEAT, 4'd0, $urandom(), 1'b0);
        push_cmd(CMD_SET_PAUSE, 4'd0, $urandom(), 1'b1);
        repeat (4) push_any(CMD_TICK);
        push_any(CMD_SCAN);
        push_cmd(CMD_SET_PAUSE, 4'd0, $urandom(), 1'b0);
        push_cmd(CMD_SET_PAUSE, 4'd1, $urandom(), 1'b1);
        push_cmd(CMD_SET_PAUSE, 4'd1, $urandom(), 1'b0);
        push_any(CMD_TICK);
        push_any(CMD_SCAN);
        push_any(CMD_SPARE_LO);
        push_any(CMD_SPARE_HI);
        push_cmd(CMD_HEARTBEAT, 4'd2, $urandom(), 1'b0);

        known = 3;
        issued = 0;
        while (issued < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
            begin
                // Let time run on, then look for the channels that went silent.
                burst = $urandom_range(1, 12);
                repeat (burst) push_any(CMD_TICK);
                push_any(CMD_SCAN);
                issued += burst + 1;
            end
            else if (pick < 37)
            begin
                push_cmd(CMD_REGISTER, $urandom_range(0, 15),
                         ($urandom_range(0, 5) == 0) ? $urandom() : $urandom_range(0, 10),
                         $urandom_range(0, 1));
                if (known < NCH)
                    known++;
                issued++;
            end
            else if (pick < 55)
            begin
                push_cmd(CMD_HEARTBEAT, pick_channel(known), $urandom(),
                         $urandom_range(0, 1));
                issued++;
            end
            else if (pick < 70)
            begin
                push_cmd(CMD_SET_PAUSE, pick_channel(known), $urandom(),
                         $urandom_range(0, 99) < 40);
                issued++;
            end
            else if (pick < 82)
            begin
                push_any(CMD_TICK);
                issued++;
            end
            else if (pick < 95)
            begin
                push_any(CMD_SCAN);
                issued++;
            end
            else
            begin
                push_any(CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)));
            end
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (cmd_queue.size() != 0 || req_if.valid)
            @(negedge clk);
        while (awaited_results.size() != 0)
            @(negedge clk);
        // Anything stray after the last scan shows up here.
        repeat (100) @(negedge clk);

        if (mismatches == 0 && awaited_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
